@@ rtl/core/ueu_pkg.sv @@
// ----------------------------------------------------------------------------
// ueu_pkg: shared types and constants
// Beat payloads, sqrt/div3 cell stage types and fixed-point constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ueu_pkg;

   localparam int DIST_W       = 32;
   localparam int DX_W         = 31;
   localparam int RAD_W        = 64;   // Q32.32 radicand
   localparam int ROOT_W       = RAD_W / 2;
   localparam int REM_W        = ROOT_W + 2;
   localparam int BASE_W       = 36;   // wide enough for a+b+c+root
   localparam int SQRT_CELLS   = ROOT_W;
   localparam int DIV3_W       = 36;
   localparam int DIV3_DIGITS  = 6;    // radix-4 digits per div3 cell
   localparam int DIV3_CELLS   = DIV3_W / (2 * DIV3_DIGITS);

   // floor(x/3) is taken on x + 3*2^32 so the dividend is never negative
   localparam logic signed [BASE_W-1:0] DIV3_OFFSET = 36'sd12884901888;
   localparam logic signed [BASE_W-1:0] DIV3_BIAS   = 36'sd4294967296;
   localparam logic signed [BASE_W-1:0] RES_MAX     = 36'sd2147483647;
   localparam logic signed [BASE_W-1:0] RES_MIN     = -36'sd2147483648;

   localparam logic [DX_W-1:0] GRID_SPACING_RESET = 31'd65536;

   typedef enum logic [1:0] {
      DIV_BY_ONE,
      DIV_BY_TWO,
      DIV_BY_THREE
   } div_sel_type;

   typedef struct packed {
      logic                     mode;
      logic signed [DIST_W-1:0] dist_a;
      logic signed [DIST_W-1:0] dist_b;
      logic signed [DIST_W-1:0] dist_c;
   } req_payload_type;

   typedef struct packed {
      logic signed [DIST_W-1:0] distance;
      logic                     saturated;
   } rsp_payload_type;

   typedef struct packed {
      logic [RAD_W-1:0]         rad;
      logic [REM_W-1:0]         rem;
      logic [ROOT_W-1:0]        root;
      logic signed [BASE_W-1:0] base;
      div_sel_type              div;
   } sqrt_stage_type;

   typedef struct packed {
      logic signed [BASE_W-1:0] num;
      div_sel_type              div;
      logic [DIV3_W-1:0]        u;
      logic [1:0]               rem;
      logic [DIV3_W-1:0]        quo;
   } div3_stage_type;

endpackage

@@ rtl/core/ueu_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// ueu_sqrt_cell: one digit of the integer square root
// Restoring digit-by-digit step; a root bit per cycle per cell when enabled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ueu_sqrt_cell
   import ueu_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           en,
   input  logic           up_valid,
   input  sqrt_stage_type up_stage,
   output logic           dn_valid,
   output sqrt_stage_type dn_stage
);

   logic           valid_ff;
   sqrt_stage_type stage_ff;
   sqrt_stage_type stage_in;
   logic [REM_W+1:0] cur;
   logic [REM_W+1:0] trial;
   logic [REM_W+1:0] diff;
   logic             take;

   always_comb begin
      cur   = {up_stage.rem, up_stage.rad[RAD_W-1 -: 2]};
      trial = {2'b00, up_stage.root, 2'b01};
      diff  = cur - trial;
      take  = (cur >= trial);
      stage_in      = up_stage;
      stage_in.rem  = take ? diff[REM_W-1:0] : cur[REM_W-1:0];
      stage_in.root = {up_stage.root[ROOT_W-2:0], take};
      stage_in.rad  = {up_stage.rad[RAD_W-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         stage_ff <= stage_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_stage = stage_ff;

endmodule

@@ rtl/core/ueu_div3_cell.sv @@
// ----------------------------------------------------------------------------
// ueu_div3_cell: floor division by three, a group of radix-4 digits per cell
// Remainder stays in 0..2, so each digit step is a 4-bit compare.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ueu_div3_cell
   import ueu_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           en,
   input  logic           up_valid,
   input  div3_stage_type up_stage,
   output logic           dn_valid,
   output div3_stage_type dn_stage
);

   logic           valid_ff;
   div3_stage_type stage_ff;
   div3_stage_type stage_in;
   logic [3:0]     t;
   logic [1:0]     qd;

   always_comb begin
      stage_in = up_stage;
      t  = '0;
      qd = '0;
      for (int j = 0; j < DIV3_DIGITS; j++) begin
         t = {stage_in.rem, stage_in.u[DIV3_W-1 -: 2]};
         priority if (t >= 4'd9) begin
            qd = 2'd3;
            stage_in.rem = 2'(t - 4'd9);
         end else if (t >= 4'd6) begin
            qd = 2'd2;
            stage_in.rem = 2'(t - 4'd6);
         end else if (t >= 4'd3) begin
            qd = 2'd1;
            stage_in.rem = 2'(t - 4'd3);
         end else begin
            qd = 2'd0;
            stage_in.rem = t[1:0];
         end
         stage_in.u   = {stage_in.u[DIV3_W-3:0], 2'b00};
         stage_in.quo = {stage_in.quo[DIV3_W-3:0], qd};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         stage_ff <= stage_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_stage = stage_ff;

endmodule

@@ rtl/core/ueu_front.sv @@
// ----------------------------------------------------------------------------
// ueu_front: operand preparation
// Squares, neighbor drop choice, discriminant test and radicand select.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ueu_front
   import ueu_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            en,
   input  logic [DX_W-1:0] dx,
   input  logic            in_valid,
   input  req_payload_type in_payload,
   output logic            out_valid,
   output sqrt_stage_type  out_stage
);

   typedef enum logic [1:0] {
      DROP_A,
      DROP_B,
      DROP_C
   } drop_type;

   typedef struct packed {
      logic                     mode;
      logic signed [DIST_W-1:0] a;
      logic signed [DIST_W-1:0] b;
      logic signed [DIST_W-1:0] c;
      logic [DIST_W-1:0]        mag_a;
      logic [DIST_W-1:0]        mag_b;
      logic [DIST_W-1:0]        mag_c;
      logic [DIST_W-1:0]        d_ab;
      logic [DIST_W-1:0]        d_bc;
      logic [DIST_W-1:0]        d_ac;
   } s2_type;

   typedef struct packed {
      logic                     mode;
      logic signed [DIST_W-1:0] a;
      logic signed [DIST_W-1:0] b;
      logic signed [DIST_W-1:0] c;
      logic [DIST_W-1:0]        mag_a;
      logic [DIST_W-1:0]        mag_b;
      logic [DIST_W-1:0]        mag_c;
      logic [RAD_W-1:0]         sq_ab;
      logic [RAD_W-1:0]         sq_bc;
      logic [RAD_W-1:0]         sq_ac;
      logic [2*DX_W-1:0]        dxsq;
      drop_type                 drop;
   } s3_type;

   typedef struct packed {
      logic                     mode;
      logic [RAD_W+1:0]         sum;
      logic [RAD_W-1:0]         lim;
      logic [2*DX_W:0]          a2;
      logic signed [DIST_W-1:0] p;
      logic signed [DIST_W-1:0] q;
      logic [DIST_W-1:0]        mag_p;
      logic [DIST_W-1:0]        mag_q;
      logic [RAD_W-1:0]         sq_pq;
      logic signed [DIST_W+1:0] sum3;
   } s4_type;

   typedef struct packed {
      logic                     use_three;
      logic [RAD_W-1:0]         disc3;
      logic [RAD_W-1:0]         rad2;
      logic                     ge_pq;
      logic                     ge_qp;
      logic signed [DIST_W-1:0] p;
      logic signed [DIST_W-1:0] q;
      logic signed [DIST_W+1:0] sum3;
   } s5_type;

   function automatic logic [DIST_W-1:0] magnitude(input logic signed [DIST_W-1:0] x);
      logic [DIST_W:0] e;
      logic [DIST_W:0] m;
      e = {x[DIST_W-1], x};
      m = x[DIST_W-1] ? (~e + 1'b1) : e;
      return m[DIST_W-1:0];
   endfunction

   function automatic logic [DIST_W-1:0] abs_diff(input logic signed [DIST_W-1:0] x,
                                                  input logic signed [DIST_W-1:0] y);
      logic signed [DIST_W:0] d;
      logic [DIST_W:0]        m;
      d = $signed({x[DIST_W-1], x}) - $signed({y[DIST_W-1], y});
      m = d[DIST_W] ? $unsigned(-d) : $unsigned(d);
      return m[DIST_W-1:0];
   endfunction

   function automatic logic signed [BASE_W-1:0] sext(input logic signed [DIST_W-1:0] x);
      return $signed({{(BASE_W-DIST_W){x[DIST_W-1]}}, x});
   endfunction

   logic            s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff;
   req_payload_type s1_ff;
   s2_type          s2_ff, s2_in;
   s3_type          s3_ff, s3_in;
   s4_type          s4_ff, s4_in;
   s5_type          s5_ff, s5_in;
   logic [DIST_W-1:0] best;
   logic signed [BASE_W-1:0] dx_s;

   // stage 2: magnitudes and pairwise differences
   always_comb begin
      s2_in.mode  = s1_ff.mode;
      s2_in.a     = s1_ff.dist_a;
      s2_in.b     = s1_ff.dist_b;
      s2_in.c     = s1_ff.dist_c;
      s2_in.mag_a = magnitude(s1_ff.dist_a);
      s2_in.mag_b = magnitude(s1_ff.dist_b);
      s2_in.mag_c = magnitude(s1_ff.dist_c);
      s2_in.d_ab  = abs_diff(s1_ff.dist_a, s1_ff.dist_b);
      s2_in.d_bc  = abs_diff(s1_ff.dist_b, s1_ff.dist_c);
      s2_in.d_ac  = abs_diff(s1_ff.dist_a, s1_ff.dist_c);
   end

   // stage 3: squares; largest magnitude is dropped, earliest wins a tie
   always_comb begin
      s3_in.mode  = s2_ff.mode;
      s3_in.a     = s2_ff.a;
      s3_in.b     = s2_ff.b;
      s3_in.c     = s2_ff.c;
      s3_in.mag_a = s2_ff.mag_a;
      s3_in.mag_b = s2_ff.mag_b;
      s3_in.mag_c = s2_ff.mag_c;
      s3_in.sq_ab = RAD_W'(s2_ff.d_ab) * RAD_W'(s2_ff.d_ab);
      s3_in.sq_bc = RAD_W'(s2_ff.d_bc) * RAD_W'(s2_ff.d_bc);
      s3_in.sq_ac = RAD_W'(s2_ff.d_ac) * RAD_W'(s2_ff.d_ac);
      s3_in.dxsq  = (2*DX_W)'(dx) * (2*DX_W)'(dx);
      s3_in.drop  = DROP_A;
      best        = s2_ff.mag_a;
      if (s2_ff.mag_b > best) begin
         s3_in.drop = DROP_B;
         best       = s2_ff.mag_b;
      end
      if (s2_ff.mag_c > best) begin
         s3_in.drop = DROP_C;
      end
   end

   // stage 4: discriminant terms and the pair for the two-neighbor rule
   always_comb begin
      s4_in.mode = s3_ff.mode;
      s4_in.sum  = (RAD_W+2)'(s3_ff.sq_ab) + (RAD_W+2)'(s3_ff.sq_bc)
                 + (RAD_W+2)'(s3_ff.sq_ac);
      s4_in.a2   = {s3_ff.dxsq, 1'b0};
      s4_in.lim  = RAD_W'(s3_ff.dxsq) + RAD_W'({s3_ff.dxsq, 1'b0});
      s4_in.sum3 = $signed({{2{s3_ff.a[DIST_W-1]}}, s3_ff.a})
                 + $signed({{2{s3_ff.b[DIST_W-1]}}, s3_ff.b})
                 + $signed({{2{s3_ff.c[DIST_W-1]}}, s3_ff.c});
      s4_in.p     = s3_ff.a;
      s4_in.q     = s3_ff.b;
      s4_in.mag_p = s3_ff.mag_a;
      s4_in.mag_q = s3_ff.mag_b;
      s4_in.sq_pq = s3_ff.sq_ab;
      if (s3_ff.mode) begin
         unique case (s3_ff.drop)
            DROP_A: begin
               s4_in.p     = s3_ff.b;
               s4_in.q     = s3_ff.c;
               s4_in.mag_p = s3_ff.mag_b;
               s4_in.mag_q = s3_ff.mag_c;
               s4_in.sq_pq = s3_ff.sq_bc;
            end
            DROP_B: begin
               s4_in.q     = s3_ff.c;
               s4_in.mag_q = s3_ff.mag_c;
               s4_in.sq_pq = s3_ff.sq_ac;
            end
            default: ;
         endcase
      end
   end

   // stage 5: sign of the discriminant, upwind tests, two-neighbor radicand
   always_comb begin
      s5_in.use_three = s4_ff.mode && (s4_ff.sum <= (RAD_W+2)'(s4_ff.lim));
      s5_in.disc3     = s4_ff.lim - s4_ff.sum[RAD_W-1:0];
      s5_in.rad2      = (RAD_W'(s4_ff.a2) > s4_ff.sq_pq) ? RAD_W'(s4_ff.a2) - s4_ff.sq_pq
                                                         : '0;
      s5_in.ge_pq     = (DIST_W+1)'(s4_ff.mag_p) >= (DIST_W+1)'(s4_ff.mag_q) + (DIST_W+1)'(dx);
      s5_in.ge_qp     = (DIST_W+1)'(s4_ff.mag_q) >= (DIST_W+1)'(s4_ff.mag_p) + (DIST_W+1)'(dx);
      s5_in.p         = s4_ff.p;
      s5_in.q         = s4_ff.q;
      s5_in.sum3      = s4_ff.sum3;
   end

   // radicand and base handed to the sqrt chain; upwind exits take root 0
   always_comb begin
      dx_s           = $signed({{(BASE_W-DX_W){1'b0}}, dx});
      out_stage.rem  = '0;
      out_stage.root = '0;
      priority if (s5_ff.use_three) begin
         out_stage.rad  = s5_ff.disc3;
         out_stage.base = $signed({{(BASE_W-DIST_W-2){s5_ff.sum3[DIST_W+1]}}, s5_ff.sum3});
         out_stage.div  = DIV_BY_THREE;
      end else if (s5_ff.ge_pq) begin
         out_stage.rad  = '0;
         out_stage.base = sext(s5_ff.q) + dx_s;
         out_stage.div  = DIV_BY_ONE;
      end else if (s5_ff.ge_qp) begin
         out_stage.rad  = '0;
         out_stage.base = sext(s5_ff.p) + dx_s;
         out_stage.div  = DIV_BY_ONE;
      end else begin
         out_stage.rad  = s5_ff.rad2;
         out_stage.base = sext(s5_ff.p) + sext(s5_ff.q);
         out_stage.div  = DIV_BY_TWO;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff <= in_payload;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
         s5_ff <= s5_in;
      end
   end

   assign out_valid = s5_valid_ff;

endmodule

@@ rtl/core/upwind_eikonal_update_top.sv @@
// ----------------------------------------------------------------------------
// upwind_eikonal_update_top: pipelined update from the req beat to rsp_valid.
// 42 register stages: 5 prep, 32 sqrt cells, 1 add, 3 div3 cells, 1 output reg;
// the accepting edge loads the first prep stage.
// Throughput one beat per cycle; input stalls only while the skid holds a beat.
// Sync reset clears valids and sets grid spacing to 1.0; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module upwind_eikonal_update_top
   import ueu_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload,
   input  logic            csr_wr_en,
   input  logic [DX_W-1:0] csr_wr_data
);

   logic [DX_W-1:0] grid_spacing_ff;
   logic            en;

   logic            sq_valid [0:SQRT_CELLS];
   sqrt_stage_type  sq_stage [0:SQRT_CELLS];

   logic                     p1_valid_ff;
   logic signed [BASE_W-1:0] p1_num_ff;
   logic signed [BASE_W-1:0] p1_num_in;
   div_sel_type              p1_div_ff;

   logic            d3_valid [0:DIV3_CELLS];
   div3_stage_type  d3_stage [0:DIV3_CELLS];

   logic signed [BASE_W-1:0] res;
   rsp_payload_type          res_payload;

   logic            rsp_valid_ff, rsp_valid_in;
   logic            skid_valid_ff, skid_valid_in;
   rsp_payload_type rsp_payload_ff, skid_payload_ff;
   logic            load_out_from_pipe, load_out_from_skid, load_skid;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_spacing_ff <= GRID_SPACING_RESET;
      end else if (csr_wr_en) begin
         grid_spacing_ff <= csr_wr_data;
      end
   end

   // the whole chain advances together; it stops only when the skid is full
   assign en        = ~skid_valid_ff;
   assign req_ready = en;

   ueu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .dx         (grid_spacing_ff),
      .in_valid   (req_valid),
      .in_payload (req_payload),
      .out_valid  (sq_valid[0]),
      .out_stage  (sq_stage[0])
   );

   for (genvar k = 0; k < SQRT_CELLS; k++) begin : g_sqrt
      ueu_sqrt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .up_valid (sq_valid[k]),
         .up_stage (sq_stage[k]),
         .dn_valid (sq_valid[k+1]),
         .dn_stage (sq_stage[k+1])
      );
   end

   assign p1_num_in = sq_stage[SQRT_CELLS].base
                    + $signed({{(BASE_W-ROOT_W){1'b0}}, sq_stage[SQRT_CELLS].root});

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (en) begin
         p1_valid_ff <= sq_valid[SQRT_CELLS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_num_ff <= p1_num_in;
         p1_div_ff <= sq_stage[SQRT_CELLS].div;
      end
   end

   always_comb begin
      d3_valid[0]     = p1_valid_ff;
      d3_stage[0].num = p1_num_ff;
      d3_stage[0].div = p1_div_ff;
      d3_stage[0].u   = $unsigned(p1_num_ff + DIV3_OFFSET);
      d3_stage[0].rem = '0;
      d3_stage[0].quo = '0;
   end

   for (genvar k = 0; k < DIV3_CELLS; k++) begin : g_div3
      ueu_div3_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .up_valid (d3_valid[k]),
         .up_stage (d3_stage[k]),
         .dn_valid (d3_valid[k+1]),
         .dn_stage (d3_stage[k+1])
      );
   end

   always_comb begin
      unique case (d3_stage[DIV3_CELLS].div)
         DIV_BY_THREE: res = $signed(d3_stage[DIV3_CELLS].quo) - DIV3_BIAS;
         DIV_BY_TWO:   res = d3_stage[DIV3_CELLS].num >>> 1;
         DIV_BY_ONE:   res = d3_stage[DIV3_CELLS].num;
         default:      res = d3_stage[DIV3_CELLS].num;
      endcase
      priority if (res > RES_MAX) begin
         res_payload.distance  = RES_MAX[DIST_W-1:0];
         res_payload.saturated = 1'b1;
      end else if (res < RES_MIN) begin
         res_payload.distance  = RES_MIN[DIST_W-1:0];
         res_payload.saturated = 1'b1;
      end else begin
         res_payload.distance  = res[DIST_W-1:0];
         res_payload.saturated = 1'b0;
      end
   end

   // output register plus one skid beat
   always_comb begin
      load_out_from_skid = skid_valid_ff && rsp_ready;
      load_out_from_pipe = !skid_valid_ff && (!rsp_valid_ff || rsp_ready);
      load_skid          = !skid_valid_ff && rsp_valid_ff && !rsp_ready
                           && d3_valid[DIV3_CELLS];
      rsp_valid_in       = rsp_valid_ff;
      skid_valid_in      = skid_valid_ff;
      if (load_out_from_skid) begin
         rsp_valid_in  = 1'b1;
         skid_valid_in = 1'b0;
      end else if (load_out_from_pipe) begin
         rsp_valid_in = d3_valid[DIV3_CELLS];
      end else if (load_skid) begin
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out_from_skid) begin
         rsp_payload_ff <= skid_payload_ff;
      end else if (load_out_from_pipe) begin
         rsp_payload_ff <= res_payload;
      end
      if (load_skid) begin
         skid_payload_ff <= res_payload;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

@@ rtl/core/ueu_checker.sv @@
// ----------------------------------------------------------------------------
// ueu_checker: port-level checks on the update block
// Output hold, reset clearing, saturation value and skid back-pressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ueu_checker
   import ueu_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_ready,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_payload
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("rsp beat changed while stalled");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid set right after reset");

   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.saturated |->
         (rsp_payload.distance == 32'sh7fffffff) || (rsp_payload.distance == 32'sh80000000))
      else $error("saturated flag with unclamped distance");

   // input only backs off while a result is parked at the output
   a_ready_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("req_ready low with no result waiting");

endmodule

bind upwind_eikonal_update_top ueu_checker u_checker (.*);
